[src/aabb_frustum_cull_defines.svh]
// ----------------------------------------------------------------------------
// aabb_frustum_cull_defines.svh
// assertion macros shared by the frustum cull block
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define AFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define AFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/afc_pkg.sv]
// ----------------------------------------------------------------------------
// afc_pkg
// types and constants of the six-plane box frustum cull
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int PLANES     = 6;
  localparam int N_W        = 14;
  localparam int D_W        = 22;
  localparam int C_W        = 24;
  localparam int E_W        = 23;
  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;
  localparam int FRAC_SHIFT = 12;
  // n*c is 14x24 signed, |n|*e is 14x23 unsigned: both fit 38 bits signed
  localparam int PROD_W     = N_W + C_W;
  // six products plus the offset term stay below 2^40 in magnitude
  localparam int SUM_W      = PROD_W + 3;

  typedef struct packed {
    logic [IDX_W-1:0]        box_index;
    logic signed [C_W-1:0]   center_x;
    logic signed [C_W-1:0]   center_y;
    logic signed [C_W-1:0]   center_z;
    logic [E_W-1:0]          extent_x;
    logic [E_W-1:0]          extent_y;
    logic [E_W-1:0]          extent_z;
  } afc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic             visible;
  } afc_out_t;

  // register layout: d in 63:42, nz in 41:28, ny in 27:14, nx in 13:0
  typedef struct packed {
    logic signed [D_W-1:0] d;
    logic signed [N_W-1:0] nz;
    logic signed [N_W-1:0] ny;
    logic signed [N_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] pz;
    logic signed [PROD_W-1:0] qx;
    logic signed [PROD_W-1:0] qy;
    logic signed [PROD_W-1:0] qz;
    logic signed [D_W-1:0]    d;
  } plane_prod_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } stage_en_t;

endpackage

[src/afc_plane_regs.sv]
// ----------------------------------------------------------------------------
// afc_plane_regs
// six plane registers written through the configuration channel
// ----------------------------------------------------------------------------
module afc_plane_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [afc_pkg::CFG_W-1:0]     cfg_data_i,
  output afc_pkg::plane_t               plane_o [afc_pkg::PLANES]
);
  import afc_pkg::*;

  plane_t plane_q [PLANES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANES; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(PLANES))) begin
      plane_q[cfg_index_i] <= plane_t'(cfg_data_i);
    end
  end

  assign plane_o = plane_q;

endmodule

[src/afc_mul_stage.sv]
// ----------------------------------------------------------------------------
// afc_mul_stage
// per-plane products of normal with center and of |normal| with extent
// ----------------------------------------------------------------------------
module afc_mul_stage (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  afc_pkg::afc_in_t            box_i,
  input  afc_pkg::plane_t             plane_i [afc_pkg::PLANES],
  output afc_pkg::plane_prod_t        prod_o  [afc_pkg::PLANES],
  output logic [afc_pkg::IDX_W-1:0]   index_o
);
  import afc_pkg::*;

  plane_prod_t               prod_d [PLANES];
  plane_prod_t               prod_q [PLANES];
  logic [IDX_W-1:0]          index_q;

  // extent along the normal's sign: n*sgn(n)*e equals |n|*e
  always_comb begin
    logic [N_W-1:0]    ax, ay, az;
    logic [PROD_W-1:0] ux, uy, uz;
    for (int i = 0; i < PLANES; i++) begin
      ax = plane_i[i].nx[N_W-1] ? N_W'(-plane_i[i].nx) : N_W'(plane_i[i].nx);
      ay = plane_i[i].ny[N_W-1] ? N_W'(-plane_i[i].ny) : N_W'(plane_i[i].ny);
      az = plane_i[i].nz[N_W-1] ? N_W'(-plane_i[i].nz) : N_W'(plane_i[i].nz);
      ux = PROD_W'(ax) * PROD_W'(box_i.extent_x);
      uy = PROD_W'(ay) * PROD_W'(box_i.extent_y);
      uz = PROD_W'(az) * PROD_W'(box_i.extent_z);
      prod_d[i].px = PROD_W'(plane_i[i].nx) * PROD_W'(box_i.center_x);
      prod_d[i].py = PROD_W'(plane_i[i].ny) * PROD_W'(box_i.center_y);
      prod_d[i].pz = PROD_W'(plane_i[i].nz) * PROD_W'(box_i.center_z);
      prod_d[i].qx = $signed(ux);
      prod_d[i].qy = $signed(uy);
      prod_d[i].qz = $signed(uz);
      prod_d[i].d  = plane_i[i].d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      index_q <= box_i.box_index;
    end
  end

  assign prod_o  = prod_q;
  assign index_o = index_q;

endmodule

[src/afc_sum_stage.sv]
// ----------------------------------------------------------------------------
// afc_sum_stage
// per-plane sums, sign test and the registered result beat
// ----------------------------------------------------------------------------
module afc_sum_stage (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  afc_pkg::plane_prod_t        prod_i [afc_pkg::PLANES],
  input  logic [afc_pkg::IDX_W-1:0]   index_i,
  output afc_pkg::afc_out_t           res_o
);
  import afc_pkg::*;

  afc_out_t          res_d;
  afc_out_t          res_q;
  logic [PLANES-1:0] pass;

  // far corner value: n.c + |n|.e + d*2^12, the plane passes when it is >= 0
  always_comb begin
    logic signed [SUM_W-1:0] s;
    for (int i = 0; i < PLANES; i++) begin
      s = SUM_W'(prod_i[i].px) + SUM_W'(prod_i[i].py) + SUM_W'(prod_i[i].pz)
        + SUM_W'(prod_i[i].qx) + SUM_W'(prod_i[i].qy) + SUM_W'(prod_i[i].qz)
        + (SUM_W'(prod_i[i].d) <<< FRAC_SHIFT);
      pass[i] = ~s[SUM_W-1];
    end
    res_d.out_index = index_i;
    res_d.visible   = &pass;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[src/aabb_frustum_cull.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// six-plane frustum visibility test of one axis-aligned box per beat
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// in      | sink      | in_valid_i / in_ready_o   | in_data_i (afc_in_t)
// out     | source    | out_valid_o / out_ready_i | out_data_o (afc_out_t)
// cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one box per cycle while the output side is not stalled
// stages: input register, multiplier register, result register
// each stage holds while the one after it is full and stalled
// reset clears the valid bits and loads all six planes with zero
// cfg_ready_o is always high
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_defines.svh"

module aabb_frustum_cull (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  afc_pkg::afc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output afc_pkg::afc_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [afc_pkg::CFG_W-1:0]     cfg_data_i
);
  import afc_pkg::*;

  plane_t           plane [PLANES];
  plane_prod_t      prod  [PLANES];
  logic [IDX_W-1:0] prod_index;
  afc_in_t          box_q;
  logic             s1_v_q, s1_v_d;
  logic             s2_v_q, s2_v_d;
  logic             out_v_q, out_v_d;
  logic             s1_ready, s2_ready, out_ready;
  stage_en_t        en;

  afc_plane_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .plane_o     (plane)
  );

  // ready chain, back to front
  assign out_ready  = !out_v_q || out_ready_i;
  assign s2_ready   = !s2_v_q || out_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    en.s1_en = s2_ready && s1_v_q;
    en.s2_en = out_ready && s2_v_q;
    s1_v_d   = s1_ready  ? in_valid_i : s1_v_q;
    s2_v_d   = s2_ready  ? s1_v_q     : s2_v_q;
    out_v_d  = out_ready ? s2_v_q     : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      box_q <= in_data_i;
    end
  end

  afc_mul_stage u_mul (
    .clk_i   (clk_i),
    .en_i    (en.s1_en),
    .box_i   (box_q),
    .plane_i (plane),
    .prod_o  (prod),
    .index_o (prod_index)
  );

  afc_sum_stage u_sum (
    .clk_i   (clk_i),
    .en_i    (en.s2_en),
    .prod_i  (prod),
    .index_i (prod_index),
    .res_o   (out_data_o)
  );

  assign out_valid_o = out_v_q;

  `AFC_ASSERT_NEXT(a_in_lands, in_valid_i && in_ready_o, s1_v_q, "accepted beat not in input stage")
  `AFC_ASSERT_NEXT(a_mul_moves, s2_v_q && out_ready, out_v_q, "product stage did not reach output")
  `AFC_ASSERT_NOW(a_empty_out_ready, !out_v_q, in_ready_o, "input stalled with empty output")

endmodule

[tb/sv/aabb_frustum_cull_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_tb
// self-checking bench for the six-plane box frustum cull
// ----------------------------------------------------------------------------
// Boxes stream in through the input channel in bursts with random gaps. The
// output side stalls on a changing pattern. Every accepted box is scored by
// an exact integer model of the plane tests against a local copy of the plane
// registers, and each result beat is checked against the oldest prediction.
// Directed tests cover the reset planes, exact-zero plane boundaries, zero
// normal components, extreme register values and writes to unused register
// indexes. Random phases follow, with cube-shaped, skewed and noise frustums.
// Plane registers change only once the pipeline has drained.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_tb;
  import afc_pkg::*;

  localparam int      SLOT_COUNT    = 1024;
  localparam int      SETTLE_CYCLES = 8;
  localparam longint  TIMEOUT_NS    = 2_000_000;
  localparam int      RANDOM_PHASES = 9;
  localparam int      PHASE_BOXES   = 105;
  localparam int      ONE_Q12       = 1 << FRAC_SHIFT;
  localparam int      N_MAX         = 8191;
  localparam int      N_MIN         = -8192;
  localparam int      D_MAX         = (1 << (D_W - 1)) - 1;
  localparam int      D_MIN         = -(1 << (D_W - 1));
  localparam int      C_MAX         = (1 << (C_W - 1)) - 1;
  localparam int      C_MIN         = -(1 << (C_W - 1));
  localparam int      E_MAX         = (1 << E_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum {FRUSTUM_CUBE, FRUSTUM_SKEW, FRUSTUM_NOISE} frustum_kind_e;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  afc_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  afc_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_W-1:0]      cfg_data_i  = '0;

  plane_t   plane_mirror [PLANES];
  plane_t   frustum_next [PLANES];
  afc_out_t pending_verdicts [$];

  int boxes_sent      = 0;
  int results_seen    = 0;
  int visible_seen    = 0;
  int reg_writes      = 0;
  int settings_loaded = 0;
  int mismatches      = 0;

  int         stall_mode = 0;
  int         stall_age  = 0;
  logic [7:0] stall_mask = 8'h01;

  aabb_frustum_cull dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still pending", $time, pending_verdicts.size());
    $display("aabb_frustum_cull_tb NOT OK");
    $finish;
  end

  // exact plane tests at the widened width
  function automatic afc_out_t cull_box(afc_in_t b);
    longint   ctr [3];
    longint   ext [3];
    longint   nrm [3];
    longint   off;
    longint   hi_sum;
    longint   lo_sum;
    afc_out_t r;
    ctr[0] = longint'($signed(b.center_x));
    ctr[1] = longint'($signed(b.center_y));
    ctr[2] = longint'($signed(b.center_z));
    ext[0] = longint'(b.extent_x);
    ext[1] = longint'(b.extent_y);
    ext[2] = longint'(b.extent_z);
    r.out_index = IDX_W'(b.box_index % SLOT_COUNT);
    r.visible   = 1'b1;
    for (int p = 0; p < PLANES; p++) begin
      nrm[0] = longint'($signed(plane_mirror[p].nx));
      nrm[1] = longint'($signed(plane_mirror[p].ny));
      nrm[2] = longint'($signed(plane_mirror[p].nz));
      hi_sum = longint'($signed(plane_mirror[p].d)) * ONE_Q12;
      lo_sum = hi_sum;
      for (int k = 0; k < 3; k++) begin
        off = (nrm[k] > 0) ? ext[k] : (nrm[k] < 0) ? -ext[k] : 0;
        hi_sum += nrm[k] * (ctr[k] + off);
        lo_sum += nrm[k] * (ctr[k] - off);
      end
      if (hi_sum < 0 && lo_sum < 0) r.visible = 1'b0;
    end
    return r;
  endfunction

  function automatic plane_t plane_of(int nx, int ny, int nz, int d);
    plane_t p;
    p.nx = N_W'(nx);
    p.ny = N_W'(ny);
    p.nz = N_W'(nz);
    p.d  = D_W'(d);
    return p;
  endfunction

  function automatic afc_in_t box_of(int idx, int cx, int cy, int cz, int ex, int ey, int ez);
    afc_in_t b;
    b.box_index = IDX_W'(idx);
    b.center_x  = C_W'(cx);
    b.center_y  = C_W'(cy);
    b.center_z  = C_W'(cz);
    b.extent_x  = E_W'(ex);
    b.extent_y  = E_W'(ey);
    b.extent_z  = E_W'(ez);
    return b;
  endfunction

  function automatic logic signed [N_W-1:0] random_normal();
    if ($urandom_range(0, 3) == 0) return '0;
    return N_W'($urandom);
  endfunction

  function automatic afc_in_t make_box(frustum_kind_e kind, int span);
    afc_in_t b;
    if (kind == FRUSTUM_NOISE || $urandom_range(0, 9) == 0) begin
      b.box_index = IDX_W'($urandom);
      b.center_x  = C_W'($urandom);
      b.center_y  = C_W'($urandom);
      b.center_z  = C_W'($urandom);
      b.extent_x  = E_W'($urandom);
      b.extent_y  = E_W'($urandom);
      b.extent_z  = E_W'($urandom);
    end else begin
      b = box_of($urandom,
                 int'($urandom_range(0, 2 * span)) - span,
                 int'($urandom_range(0, 2 * span)) - span,
                 int'($urandom_range(0, 2 * span)) - span,
                 $urandom_range(0, span / 2),
                 $urandom_range(0, span / 2),
                 $urandom_range(0, span / 2));
    end
    return b;
  endfunction

  // output side stall pattern
  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_age   <= $urandom_range(20, 200);
      stall_mask  <= 8'($urandom_range(1, 255));
      out_ready_i <= 1'b1;
    end else begin
      stall_age <= stall_age - 1;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ready_i <= stall_mask[0];
          stall_mask  <= {stall_mask[0], stall_mask[7:1]};
        end
      endcase
    end
  end

  // result beat check
  always @(posedge clk_i) begin : verdict_check
    afc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected, got index %0d visible %0b",
                 $time, out_data_o.out_index, out_data_o.visible);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data_o.out_index !== want.out_index) begin
          $display("%0t: out_index expected %0d got %0d",
                   $time, want.out_index, out_data_o.out_index);
          mismatches++;
        end
        if (out_data_o.visible !== want.visible) begin
          $display("%0t: visible of box %0d expected %0b got %0b",
                   $time, want.out_index, want.visible, out_data_o.visible);
          mismatches++;
        end
        if (want.visible) visible_seen++;
      end
    end
  end

  task automatic send_box(afc_in_t b);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts = {pending_verdicts, cull_box(b)};
    boxes_sent++;
  endtask

  task automatic sender_gap();
    int gap;
    case ($urandom_range(0, 7))
      0, 1:       gap = 0;
      2, 3, 4, 5: gap = $urandom_range(1, 3);
      6:          gap = $urandom_range(4, 12);
      default:    gap = $urandom_range(20, 40);
    endcase
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < PLANES) plane_mirror[idx] = data;
    reg_writes++;
  endtask

  task automatic load_frustum(bit spare_too);
    drain_results();
    for (int i = 0; i < PLANES; i++) write_reg(CFG_IDX_W'(i), frustum_next[i]);
    if (spare_too) begin
      write_reg(REG_SPARE_LO, {$urandom, $urandom});
      write_reg(REG_SPARE_HI, '1);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_loaded++;
  endtask

  // all-zero planes pass everything
  task automatic test_reset_visible();
    send_box(box_of(0, 0, 0, 0, 0, 0, 0));
    send_box(box_of(SLOT_COUNT - 1, C_MAX, C_MAX, C_MAX, E_MAX, E_MAX, E_MAX));
    send_box(box_of(512, C_MIN, C_MIN, C_MIN, 0, 0, 0));
    send_box(box_of(341, C_MIN, C_MAX, 0, E_MAX, 0, E_MAX));
    drain_results();
  endtask

  // plane values of exactly zero, negative normals, zero normal components
  task automatic test_plane_boundary();
    foreach (frustum_next[i]) frustum_next[i] = '0;
    frustum_next[0] = plane_of(ONE_Q12, 0, 0, 0);
    frustum_next[1] = plane_of(0, -ONE_Q12, 0, 0);
    frustum_next[2] = plane_of(0, 0, ONE_Q12, -1280);
    load_frustum(1'b0);
    send_box(box_of(1, -10, 0, 1280, 10, 0, 0));
    send_box(box_of(2, -11, 0, 1280, 10, 0, 0));
    send_box(box_of(3, 0, 300, 1280, 0, 300, 0));
    send_box(box_of(4, 0, 301, 1280, 0, 300, 0));
    send_box(box_of(5, 0, 0, 1279, 0, 0, 0));
    send_box(box_of(6, 0, 0, 1000, 0, E_MAX, 280));
    send_box(box_of(7, -10, 0, 1280, 10, E_MAX, E_MAX));
    send_box(box_of(8, -11, 0, 1280, 10, E_MAX, E_MAX));
    drain_results();
  endtask

  task automatic test_register_extremes();
    foreach (frustum_next[i]) frustum_next[i] = '1;
    load_frustum(1'b0);
    send_box(box_of(9, 0, 0, 0, 0, 0, 0));
    send_box(box_of(10, C_MIN, C_MIN, C_MIN, E_MAX, E_MAX, E_MAX));
    frustum_next[0] = plane_of(N_MIN, N_MAX, 0, D_MIN);
    frustum_next[1] = plane_of(N_MAX, N_MIN, N_MAX, D_MAX);
    frustum_next[2] = plane_of(0, 0, 0, D_MAX);
    frustum_next[3] = plane_of(N_MIN, N_MIN, N_MIN, D_MAX);
    frustum_next[4] = plane_of(N_MAX, N_MAX, N_MAX, 0);
    frustum_next[5] = '0;
    load_frustum(1'b0);
    send_box(box_of(11, C_MAX, C_MAX, C_MAX, E_MAX, E_MAX, E_MAX));
    send_box(box_of(12, C_MIN, C_MAX, C_MIN, E_MAX, 0, E_MAX));
    send_box(box_of(13, 0, 0, 0, E_MAX, E_MAX, E_MAX));
    send_box(box_of(14, -256, 256, 0, 0, 0, 0));
    drain_results();
  endtask

  // indexes past the last plane must not disturb the planes
  task automatic test_spare_registers();
    foreach (frustum_next[i]) frustum_next[i] = '0;
    load_frustum(1'b1);
    send_box(box_of(15, 0, 0, 0, 0, 0, 0));
    send_box(box_of(16, C_MIN, C_MAX, C_MIN, 0, E_MAX, 0));
    send_box(box_of(17, C_MAX, 0, C_MIN, E_MAX, 0, 0));
    drain_results();
  endtask

  task automatic test_random_frustums();
    frustum_kind_e kind;
    int            span;
    int            reach;
    int            left;
    int            burst;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = frustum_kind_e'(phase % 3);
      span = 1 << 20;
      case (kind)
        FRUSTUM_CUBE: begin
          reach = $urandom_range(16, D_MAX);
          span  = reach + reach / 2;
          frustum_next[0] = plane_of(ONE_Q12, 0, 0, reach);
          frustum_next[1] = plane_of(-ONE_Q12, 0, 0, reach);
          frustum_next[2] = plane_of(0, ONE_Q12, 0, reach);
          frustum_next[3] = plane_of(0, -ONE_Q12, 0, reach);
          frustum_next[4] = plane_of(0, 0, ONE_Q12, reach);
          frustum_next[5] = plane_of(0, 0, -ONE_Q12, reach);
        end
        FRUSTUM_SKEW: begin
          foreach (frustum_next[i]) begin
            frustum_next[i].nx = random_normal();
            frustum_next[i].ny = random_normal();
            frustum_next[i].nz = random_normal();
            frustum_next[i].d  = D_W'($urandom_range(1 << 20, D_MAX));
          end
        end
        default: begin
          foreach (frustum_next[i]) frustum_next[i] = {$urandom, $urandom};
        end
      endcase
      load_frustum($urandom_range(0, 2) == 0);
      left = PHASE_BOXES;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        for (int j = 0; j < burst && left > 0; j++) begin
          send_box(make_box(kind, span));
          left--;
        end
        if (phase == 4 && left < PHASE_BOXES / 2 && left + burst >= PHASE_BOXES / 2)
          drain_results();
        else
          sender_gap();
      end
    end
    drain_results();
  endtask

  initial begin
    foreach (plane_mirror[i]) plane_mirror[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_visible();
    test_plane_boundary();
    test_register_extremes();
    test_spare_registers();
    test_random_frustums();
    drain_results();
    $display("run: %0d boxes tested against %0d plane settings, %0d results, %0d visible",
             boxes_sent, settings_loaded, results_seen, visible_seen);
    $display("run: %0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("aabb_frustum_cull_tb OK");
    end else begin
      $display("aabb_frustum_cull_tb NOT OK");
    end
    $finish;
  end

endmodule
